// ===== rtl/ppct_pkg.sv =====
package ppct_pkg;

    // Opcodes
    localparam logic [2:0] OP_BOX3D_SPHERE   = 3'd0;
    localparam logic [2:0] OP_SPHERE_SPHERE  = 3'd1;
    localparam logic [2:0] OP_BOX2D_BOX2D    = 3'd2;
    localparam logic [2:0] OP_BOX2D_CIRCLE   = 3'd3;
    localparam logic [2:0] OP_CIRCLE_CIRCLE  = 3'd4;

    typedef logic [2:0]         opcode_t;
    typedef logic signed [23:0] coord_t;
    typedef logic signed [24:0] diff_t;
    typedef logic [24:0]        mag_t;
    typedef logic [48:0]        square_t;
    typedef logic [49:0]        dist_t;

    // Input fields, first field in the lowest bits
    typedef struct packed {
        coord_t second_w;
        coord_t second_z;
        coord_t second_y;
        coord_t second_x;
        coord_t first_hi_z;
        coord_t first_hi_y;
        coord_t first_hi_x;
        coord_t first_lo_z;
        coord_t first_lo_y;
        coord_t first_lo_x;
    } pair_t;

    typedef struct packed {
        coord_t z;
        coord_t y;
        coord_t x;
    } point_t;

    // How the final compare is made
    typedef struct packed {
        logic active;
        logic box2d;
        logic box_hit;
        logic strict;
    } mode_t;

    typedef struct packed {
        mode_t  mode;
        mag_t   mx;
        mag_t   my;
        mag_t   mz;
        mag_t   mr;
        point_t contact;
    } gap_t;

    typedef struct packed {
        mode_t   mode;
        square_t qx;
        square_t qy;
        square_t qz;
        square_t qr;
        point_t  contact;
    } sqr_t;

    typedef struct packed {
        mode_t   mode;
        dist_t   dist_sq;
        square_t r2;
        point_t  contact;
    } sum_t;

    typedef struct packed {
        point_t contact;
        logic   hit;
    } result_t;

    typedef struct packed {
        coord_t near_pt;
        mag_t   gap;
    } axis_t;

    function automatic diff_t sub_ext(coord_t a, coord_t b);
        sub_ext = diff_t'(a) - diff_t'(b);
    endfunction

    function automatic diff_t add_ext(coord_t a, coord_t b);
        add_ext = diff_t'(a) + diff_t'(b);
    endfunction

    function automatic mag_t magnitude(diff_t d);
        diff_t n;
        n = -d;
        magnitude = d[24] ? mag_t'(n) : mag_t'(d);
    endfunction

    // Clamp a centre coordinate to the box on one axis; below minimum wins
    function automatic axis_t axis_clamp(coord_t c, coord_t lo, coord_t hi);
        axis_t r;
        if (c < lo)
        begin
            r.near_pt = lo;
            r.gap     = mag_t'(sub_ext(lo, c));
        end
        else if (c > hi)
        begin
            r.near_pt = hi;
            r.gap     = mag_t'(sub_ext(c, hi));
        end
        else
        begin
            r.near_pt = c;
            r.gap     = '0;
        end
        return r;
    endfunction

endpackage

// ===== rtl/ppct_gap.sv =====
module ppct_gap
    import ppct_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  opcode_t opcode,
    input  pair_t   pair,
    output logic    out_valid,
    input  logic    out_ready,
    output gap_t    out_data
);

    logic  valid_reg;
    gap_t  data_reg;
    gap_t  data_next;
    axis_t ax;
    axis_t ay;
    axis_t az;
    logic  load;

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    assign ax = axis_clamp(pair.second_x, pair.first_lo_x, pair.first_hi_x);
    assign ay = axis_clamp(pair.second_y, pair.first_lo_y, pair.first_hi_y);
    assign az = axis_clamp(pair.second_z, pair.first_lo_z, pair.first_hi_z);

    // Form per-axis gaps, radius and compare mode for the opcode
    always_comb
    begin
        data_next = '0;
        case (opcode)
            OP_BOX3D_SPHERE:
            begin
                data_next.mode.active = 1'b1;
                data_next.mx          = ax.gap;
                data_next.my          = ay.gap;
                data_next.mz          = az.gap;
                data_next.mr          = magnitude(diff_t'(pair.second_w));
                data_next.contact.x   = ax.near_pt;
                data_next.contact.y   = ay.near_pt;
                data_next.contact.z   = az.near_pt;
            end
            OP_SPHERE_SPHERE:
            begin
                data_next.mode.active = 1'b1;
                data_next.mode.strict = 1'b1;
                data_next.mx = magnitude(sub_ext(pair.second_x, pair.first_lo_x));
                data_next.my = magnitude(sub_ext(pair.second_y, pair.first_lo_y));
                data_next.mz = magnitude(sub_ext(pair.second_z, pair.first_lo_z));
                data_next.mr = magnitude(add_ext(pair.first_hi_x, pair.second_w));
            end
            OP_BOX2D_BOX2D:
            begin
                data_next.mode.active  = 1'b1;
                data_next.mode.box2d   = 1'b1;
                data_next.mode.box_hit = !(pair.second_z < pair.first_lo_x ||
                                           pair.second_x > pair.first_hi_x ||
                                           pair.second_w < pair.first_lo_y ||
                                           pair.second_y > pair.first_hi_y);
            end
            OP_BOX2D_CIRCLE:
            begin
                data_next.mode.active = 1'b1;
                data_next.mx          = ax.gap;
                data_next.my          = ay.gap;
                data_next.mr          = magnitude(diff_t'(pair.second_w));
            end
            OP_CIRCLE_CIRCLE:
            begin
                data_next.mode.active = 1'b1;
                data_next.mx = magnitude(sub_ext(pair.second_x, pair.first_lo_x));
                data_next.my = magnitude(sub_ext(pair.second_y, pair.first_lo_y));
                data_next.mr = magnitude(add_ext(pair.first_hi_x, pair.second_w));
            end
            default:
            begin
                data_next = '0;
            end
        endcase
    end

    // Advance valid on transfer or drain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== rtl/ppct_square.sv =====
module ppct_square
    import ppct_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  gap_t in_data,
    output logic out_valid,
    input  logic out_ready,
    output sqr_t out_data
);

    logic  valid_reg;
    sqr_t  data_reg;
    sqr_t  data_next;
    dist_t px;
    dist_t py;
    dist_t pz;
    dist_t pr;
    logic  load;

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    // Square the magnitudes; each fits in 49 bits
    assign px = dist_t'(in_data.mx) * dist_t'(in_data.mx);
    assign py = dist_t'(in_data.my) * dist_t'(in_data.my);
    assign pz = dist_t'(in_data.mz) * dist_t'(in_data.mz);
    assign pr = dist_t'(in_data.mr) * dist_t'(in_data.mr);

    always_comb
    begin
        data_next.mode    = in_data.mode;
        data_next.qx      = px[48:0];
        data_next.qy      = py[48:0];
        data_next.qz      = pz[48:0];
        data_next.qr      = pr[48:0];
        data_next.contact = in_data.contact;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== rtl/ppct_sum.sv =====
module ppct_sum
    import ppct_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  sqr_t in_data,
    output logic out_valid,
    input  logic out_ready,
    output sum_t out_data
);

    logic valid_reg;
    sum_t data_reg;
    sum_t data_next;
    logic load;

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    // Add the three squared gaps
    always_comb
    begin
        data_next.mode    = in_data.mode;
        data_next.dist_sq = dist_t'(in_data.qx) + dist_t'(in_data.qy)
                          + dist_t'(in_data.qz);
        data_next.r2      = in_data.qr;
        data_next.contact = in_data.contact;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== rtl/ppct_decide.sv =====
module ppct_decide
    import ppct_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  sum_t    in_data,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    logic    valid_reg;
    result_t data_reg;
    result_t data_next;
    dist_t   r2_ext;
    logic    below;
    logic    equal;
    logic    load;

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    assign r2_ext = dist_t'(in_data.r2);
    assign below  = in_data.dist_sq < r2_ext;
    assign equal  = in_data.dist_sq == r2_ext;

    // Pick the hit rule; touching is a miss only for sphere pairs
    always_comb
    begin
        data_next.contact = in_data.contact;
        if (!in_data.mode.active)
            data_next.hit = 1'b0;
        else if (in_data.mode.box2d)
            data_next.hit = in_data.mode.box_hit;
        else
            data_next.hit = below || (equal && !in_data.mode.strict);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== rtl/primitive_pair_collision_test.sv =====
// Throughput: one shape pair per cycle while the output is not stalled.
// Four register stages (clamp or difference, square, sum, compare),
// each with its own valid bit.
// A stage takes new data whenever it is empty or its contents move on.
// Reset: rst_n clears all valid bits asynchronously; no output is valid.
module primitive_pair_collision_test
    import ppct_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // first_lo_x, first_lo_y, first_lo_z, first_hi_x, first_hi_y,
    // first_hi_z, second_x, second_y, second_z, second_w
    input  logic [239:0] s_axis_tdata,
    // opcode
    input  logic [2:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // hit, contact_x, contact_y, contact_z, 7 zero bits
    output logic [79:0]  m_axis_tdata
);

    gap_t    gap_data;
    sqr_t    sqr_data;
    sum_t    sum_data;
    result_t res_data;
    logic    gap_valid;
    logic    gap_ready;
    logic    sqr_valid;
    logic    sqr_ready;
    logic    sum_valid;
    logic    sum_ready;

    // Clamp to box or take centre differences
    ppct_gap u_gap (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .opcode    (opcode_t'(s_axis_tuser)),
        .pair      (pair_t'(s_axis_tdata)),
        .out_valid (gap_valid),
        .out_ready (gap_ready),
        .out_data  (gap_data)
    );

    // Square gaps and radius
    ppct_square u_square (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (gap_valid),
        .in_ready  (gap_ready),
        .in_data   (gap_data),
        .out_valid (sqr_valid),
        .out_ready (sqr_ready),
        .out_data  (sqr_data)
    );

    // Sum squared distance
    ppct_sum u_sum (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sqr_valid),
        .in_ready  (sqr_ready),
        .in_data   (sqr_data),
        .out_valid (sum_valid),
        .out_ready (sum_ready),
        .out_data  (sum_data)
    );

    // Compare and hold the result for the output transfer
    ppct_decide u_decide (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sum_valid),
        .in_ready  (sum_ready),
        .in_data   (sum_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (res_data)
    );

    assign m_axis_tdata = {7'b0, res_data};

endmodule

// ===== rtl/ppct_checker.sv =====
module ppct_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [79:0]  m_axis_tdata
);

    // Output valid holds until the transfer
    a_out_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output valid dropped while stalled");

    // A stalled result keeps its payload
    a_out_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("output payload changed while stalled");

    // A draining output never stalls the input
    a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output drains");

    // With the output draining, each transfer reaches the output
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) ##1 m_axis_tready ##1 m_axis_tready
        ##1 m_axis_tready |=> m_axis_tvalid)
        else $error("result missing after pipeline latency");

endmodule

bind primitive_pair_collision_test ppct_checker u_ppct_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
